[hdl/pmst_pkg.sv]
// shared types and constants for the minimum spanning tree core
package pmst_pkg;

  localparam int DefMaxNodes = 8;
  localparam int WeightW     = 16;
  localparam int KeyW        = 17;
  localparam int VidW        = 6;
  localparam int CountW      = 7;

  localparam logic [KeyW-1:0] KeyInf = 17'h10000;

  localparam logic CfgVertexCount = 1'b0;
  localparam logic CfgStartVertex = 1'b1;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic init;      // clear per-vertex state, seed root key
    logic scan_clr;  // reset running minimum
    logic scan_en;   // compare one vertex against the minimum
    logic mark;      // mark selected vertex done
    logic relax_en;  // relax one vertex from the selected row
    logic emit;      // drive a result transaction
  } pmst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;     // a finite minimum was found in the last scan
  } pmst_stat_t;

endpackage

[hdl/pmst_ram.sv]
// generic single-port-write ram with registered read
module pmst_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/pmst_ctrl.sv]
// sequencer for the tree run: scan, mark, relax and emit phases
module pmst_ctrl #(
  parameter int MaxNodes = pmst_pkg::DefMaxNodes
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        run,
  input  logic [$clog2(MaxNodes)-1:0] n_last,
  input  logic [$clog2(MaxNodes)-1:0] root,
  input  pmst_pkg::pmst_stat_t        stat,
  output pmst_pkg::pmst_cmd_t         cmd,
  output logic [$clog2(MaxNodes)-1:0] idx,
  output logic [$clog2(MaxNodes)-1:0] emit_last_idx,
  output logic                        busy
);
  import pmst_pkg::*;
  localparam int IW = $clog2(MaxNodes);

  typedef enum logic [2:0] {
    IDLE, INIT, SCAN, MARK, RELAX, EMIT
  } state_t;

  state_t        state;
  logic [IW-1:0] step;
  logic [IW-1:0] nl;
  logic [IW-1:0] rt;

  assign busy = (state != IDLE);
  assign emit_last_idx = (rt == nl) ? nl - IW'(1) : nl;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:  cmd = '0;
      INIT:  begin cmd.init = 1'b1; cmd.scan_clr = 1'b1; end
      SCAN:  cmd.scan_en = 1'b1;
      MARK:  begin cmd.mark = stat.found; end
      RELAX: cmd.relax_en = 1'b1;
      EMIT:  cmd.emit = (idx != rt);
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
      step  <= '0;
      nl    <= '0;
      rt    <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (run) begin
            nl    <= n_last;
            rt    <= root;
            state <= INIT;
          end
        end
        INIT: begin
          idx   <= '0;
          step  <= '0;
          state <= SCAN;
        end
        SCAN: begin
          if (idx == nl) begin
            idx   <= '0;
            state <= MARK;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        MARK: begin
          idx <= '0;
          state <= stat.found ? RELAX : EMIT;
        end
        RELAX: begin
          // ram read is registered, so its data follows idx in the next cycle; the last column lands in the next state
          if (idx == nl) begin
            idx <= '0;
            if (step == nl) begin
              state <= EMIT;
            end else begin
              step  <= step + IW'(1);
              state <= SCAN;
            end
          end else begin
            idx <= idx + IW'(1);
          end
        end
        EMIT: begin
          if (idx == nl) begin
            state <= IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

[hdl/pmst_dp.sv]
// per-vertex keys, minimum scan, relaxation and matrix store
module pmst_dp #(
  parameter int MaxNodes = pmst_pkg::DefMaxNodes
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load_en,
  input  logic [$clog2(MaxNodes)-1:0] load_row,
  input  logic [$clog2(MaxNodes)-1:0] load_col,
  input  logic [pmst_pkg::WeightW-1:0] load_weight,
  input  logic                        load_present,
  input  logic [$clog2(MaxNodes)-1:0] root,
  input  pmst_pkg::pmst_cmd_t         cmd,
  input  logic [$clog2(MaxNodes)-1:0] idx,
  input  logic [$clog2(MaxNodes)-1:0] emit_last_idx,
  output pmst_pkg::pmst_stat_t        stat,
  output logic                        res_valid,
  output logic [pmst_pkg::VidW-1:0]   res_vertex,
  output logic [pmst_pkg::VidW-1:0]   res_parent,
  output logic [pmst_pkg::WeightW-1:0] res_weight,
  output logic                        res_reach,
  output logic                        res_last
);
  import pmst_pkg::*;
  localparam int IW = $clog2(MaxNodes);
  // matrix is addressed as {row, col}, so each side spans a power of two
  localparam int Cells = 1 << (2 * IW);
  localparam int AW = 2 * IW;

  logic                pres_rd;  // present bit for the cell on rdata
  logic [MaxNodes-1:0] done;
  logic [KeyW-1:0]     key    [MaxNodes];
  logic [IW-1:0]       parent [MaxNodes];

  logic [KeyW-1:0] min_key;
  logic [IW-1:0]   sel;
  logic [IW-1:0]   rd_col;   // column whose weight is on rdata
  logic            rd_ok;
  logic [WeightW-1:0] rdata;
  logic [Cells-1:0] pres_bits;
  logic [AW-1:0]   waddr, raddr;

  assign waddr = {load_row, load_col};
  assign raddr = {sel, idx};
  assign stat.found = (min_key != KeyInf);

  pmst_ram #(.Width(WeightW), .Depth(Cells)) u_wram (
    .clk  (clk),
    .we   (load_en),
    .waddr(waddr),
    .wdata(load_weight),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pres_bits <= '0;
      done      <= '0;
      res_valid <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      res_valid <= cmd.emit;
      rd_ok     <= cmd.relax_en;
      if (load_en) begin
        pres_bits[waddr] <= load_present;
      end
      if (cmd.init) begin
        done <= '0;
      end else if (cmd.mark) begin
        done[sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_col  <= idx;
    pres_rd <= pres_bits[raddr];
    if (cmd.init) begin
      for (int i = 0; i < MaxNodes; i++) begin
        key[i]    <= (IW'(i) == root) ? '0 : KeyInf;
        parent[i] <= '0;
      end
    end else if (rd_ok && pres_rd && !done[rd_col]
                 && {1'b0, rdata} < key[rd_col]) begin
      key[rd_col]    <= {1'b0, rdata};
      parent[rd_col] <= sel;
    end
    if (cmd.scan_clr || cmd.mark) begin
      min_key <= KeyInf;
    end else if (cmd.scan_en && !done[idx] && key[idx] < min_key) begin
      min_key <= key[idx];
      sel     <= idx;
    end
    if (cmd.emit) begin
      res_vertex <= VidW'(idx);
      res_reach  <= done[idx];
      res_parent <= done[idx] ? VidW'(parent[idx]) : '0;
      res_weight <= done[idx] ? key[idx][WeightW-1:0] : '0;
      res_last   <= (idx == emit_last_idx);
    end
  end
endmodule

[hdl/prim_minimum_spanning_tree_core.sv]
// top level of the prim minimum spanning tree core
// A load transaction (op 0) writes one adjacency entry and never raises
// busy. A run transaction (op 1) grows the tree from start_vertex over
// n = min(vertex_count, MAX_NODES) vertices: an init step, then each of
// up to n steps scans all n keys, marks the chosen vertex and relaxes its
// row through the registered weight memory port (the last read resolving
// in the following cycle), then an emit phase over all n vertices; growth
// stops early when a scan finds no finite key. Results come out one per
// cycle during the emit phase, each in the cycle after its emit step, in
// vertex order with a gap where the start vertex is skipped, so the last
// result shows in the first cycle after busy falls unless the start vertex
// is the last vertex; result_valid is high for exactly one cycle each and
// the receiver cannot stall them. A run with n below 2 or start_vertex not
// below n returns no results.
module prim_minimum_spanning_tree_core #(
  parameter int MAX_NODES = pmst_pkg::DefMaxNodes
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [5:0]                    row_vertex,
  input  logic [5:0]                    col_vertex,
  input  logic [pmst_pkg::WeightW-1:0]  edge_weight,
  input  logic                          edge_present,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pmst_pkg::CountW-1:0]   cfg_data,
  output logic                          result_valid,
  output logic [pmst_pkg::VidW-1:0]     vertex_id,
  output logic [pmst_pkg::VidW-1:0]     parent_vertex,
  output logic [pmst_pkg::WeightW-1:0]  tree_weight,
  output logic                          reachable,
  output logic                          last
);
  import pmst_pkg::*;
  localparam int IW = $clog2(MAX_NODES);

  logic [CountW-1:0] vertex_count;
  logic [VidW-1:0]   start_vertex;
  logic              ctrl_busy;
  logic              accept;
  logic              load_en;
  logic              run;
  logic [CountW-1:0] n_eff;
  logic [IW-1:0]     idx, emit_last_idx;
  pmst_cmd_t         cmd;
  pmst_stat_t        stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CountW'(8);
      start_vertex <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgVertexCount: vertex_count <= cfg_data;
        CfgStartVertex: start_vertex <= cfg_data[VidW-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = ctrl_busy;
  assign accept = start && !ctrl_busy;
  // writes outside the matrix are dropped
  assign load_en = accept && (op == OpLoad)
                   && ({1'b0, row_vertex} < CountW'(MAX_NODES))
                   && ({1'b0, col_vertex} < CountW'(MAX_NODES));
  assign n_eff = (vertex_count > CountW'(MAX_NODES)) ? CountW'(MAX_NODES)
                                                     : vertex_count;
  // degenerate runs produce nothing
  assign run = accept && (op == OpRun) && (n_eff >= CountW'(2))
               && ({1'b0, start_vertex} < n_eff);

  pmst_ctrl #(.MaxNodes(MAX_NODES)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .run          (run),
    .n_last       (IW'(n_eff - CountW'(1))),
    .root         (IW'(start_vertex)),
    .stat         (stat),
    .cmd          (cmd),
    .idx          (idx),
    .emit_last_idx(emit_last_idx),
    .busy         (ctrl_busy)
  );

  pmst_dp #(.MaxNodes(MAX_NODES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .load_en      (load_en),
    .load_row     (IW'(row_vertex)),
    .load_col     (IW'(col_vertex)),
    .load_weight  (edge_weight),
    .load_present (edge_present),
    .root         (IW'(start_vertex)),
    .cmd          (cmd),
    .idx          (idx),
    .emit_last_idx(emit_last_idx),
    .stat         (stat),
    .res_valid    (result_valid),
    .res_vertex   (vertex_id),
    .res_parent   (parent_vertex),
    .res_weight   (tree_weight),
    .res_reach    (reachable),
    .res_last     (last)
  );
endmodule

[bench/testbench.sv]
// self-checking testbench for the prim minimum spanning tree core
`timescale 1ns / 100ps

module testbench;
  import pmst_pkg::*;

  localparam int Nodes      = DefMaxNodes;
  localparam int CycleLimit = 2000000;

  // one result transaction as the core should produce it
  typedef struct {
    logic [VidW-1:0]    vid;
    logic [VidW-1:0]    parent;
    logic [WeightW-1:0] weight;
    logic               reach;
    logic               lst;
  } tree_entry_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                op = OpLoad;
  logic [5:0]          row_vertex = '0;
  logic [5:0]          col_vertex = '0;
  logic [WeightW-1:0]  edge_weight = '0;
  logic                edge_present = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CfgVertexCount;
  logic [CountW-1:0]   cfg_data = '0;
  logic                result_valid;
  logic [VidW-1:0]     vertex_id;
  logic [VidW-1:0]     parent_vertex;
  logic [WeightW-1:0]  tree_weight;
  logic                reachable;
  logic                last;

  prim_minimum_spanning_tree_core uut (
    .clk, .rst, .start, .busy, .op, .row_vertex, .col_vertex, .edge_weight,
    .edge_present, .cfg_we, .cfg_index, .cfg_data, .result_valid, .vertex_id,
    .parent_vertex, .tree_weight, .reachable, .last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the core's matrix and registers
  logic [WeightW-1:0] edge_weights [Nodes*Nodes];
  logic               edge_exists  [Nodes*Nodes];
  logic [CountW-1:0]  vertex_count_q = 7'd8;
  logic [VidW-1:0]    root_q = '0;

  tree_entry_t spanning_q[$];
  int          error_count = 0;
  int          result_count = 0;
  int          load_count = 0;
  int          run_count = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // prim's algorithm over the shadow matrix: linear min scan, ties to the
  // lowest index, parent recorded when the key drops
  task automatic predict_tree();
    int                  n;
    int                  u;
    logic [KeyW-1:0]     minkey;
    logic                done_v [Nodes];
    logic [KeyW-1:0]     key_v [Nodes];
    logic [VidW-1:0]     par_v [Nodes];
    int                  emitted;
    tree_entry_t         e;
    n = (vertex_count_q > Nodes) ? Nodes : int'(vertex_count_q);
    if (n < 2 || int'(root_q) >= n) return;
    for (int v = 0; v < Nodes; v++) begin
      done_v[v] = 1'b0;
      key_v[v]  = KeyInf;
      par_v[v]  = '0;
    end
    key_v[root_q] = '0;
    for (int s = 0; s < n; s++) begin
      u = n;
      minkey = KeyInf;
      for (int v = 0; v < n; v++)
        if (!done_v[v] && key_v[v] < minkey) begin
          minkey = key_v[v];
          u = v;
        end
      if (u >= n) break;
      done_v[u] = 1'b1;
      for (int v = 0; v < n; v++)
        if (edge_exists[u*Nodes+v] && !done_v[v] &&
            {1'b0, edge_weights[u*Nodes+v]} < key_v[v]) begin
          key_v[v] = {1'b0, edge_weights[u*Nodes+v]};
          par_v[v] = VidW'(u);
        end
    end
    emitted = 0;
    for (int v = 0; v < n; v++) begin
      if (v == int'(root_q)) continue;
      emitted++;
      e.vid    = VidW'(v);
      e.reach  = done_v[v];
      e.parent = done_v[v] ? par_v[v] : '0;
      e.weight = done_v[v] ? key_v[v][WeightW-1:0] : '0;
      e.lst    = (emitted == n - 1);
      spanning_q.push_back(e);
    end
  endtask

  // send one transaction; returns just after the accepting edge with start
  // still high so a back-to-back item needs no second assignment
  task automatic send_item(input logic o, input logic [5:0] r, input logic [5:0] c,
                           input logic [WeightW-1:0] w, input logic p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    op           <= o;
    row_vertex   <= r;
    col_vertex   <= c;
    edge_weight  <= w;
    edge_present <= p;
    // busy only moves on the rising edge, so the falling edge is a safe look
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (o == OpLoad) begin
      load_count++;
      if (r < Nodes && c < Nodes) begin
        edge_weights[r*Nodes+c] = w;
        edge_exists[r*Nodes+c]  = p;
      end
    end else begin
      run_count++;
      predict_tree();
    end
  endtask

  task automatic load_edge(input int r, input int c, input int w, input bit p);
    send_item(OpLoad, 6'(r), 6'(c), WeightW'(w), p);
  endtask

  task automatic run_tree();
    send_item(OpRun, 6'($urandom), 6'($urandom), WeightW'($urandom), 1'($urandom));
  endtask

  // wait until every result is in and the core is idle again
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (spanning_q.size() != 0) @(posedge clk);
    repeat (4 * Nodes) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CountW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgVertexCount) vertex_count_q = CountW'(value);
    else root_q = VidW'(value);
    @(posedge clk);
  endtask

  task automatic set_graph(input int count, input int root);
    drain();
    write_reg(CfgVertexCount, count);
    write_reg(CfgStartVertex, root);
  endtask

  // every cell gets a write first so no stale weight is ever looked at
  task automatic test_clear_matrix();
    no_gaps = 1'b1;
    for (int i = 0; i < Nodes * Nodes; i++)
      load_edge(i / Nodes, i % Nodes, $urandom, 1'b0);
    no_gaps = 1'b0;
    // reset registers, empty graph: every vertex unreachable
    run_tree();
  endtask

  task automatic test_special_cases();
    // writes outside the matrix are dropped
    load_edge(63, 0, 5, 1'b1);
    load_edge(0, 63, 5, 1'b1);
    load_edge(Nodes, Nodes, 5, 1'b1);
    // weight extremes, a tie for vertex 1 between parents 0 and 2, a self edge, one-way entries
    load_edge(0, 1, 16'hffff, 1'b1);
    load_edge(0, 2, 0, 1'b1);
    load_edge(2, 1, 16'hffff, 1'b1);
    load_edge(0, 0, 0, 1'b1);
    load_edge(3, 0, 1, 1'b1);
    load_edge(2, 4, 7, 1'b1);
    load_edge(1, 5, 7, 1'b1);
    run_tree();
    // start at the last vertex, reaches nothing through row 7
    set_graph(8, 7);
    run_tree();
    // count above the matrix size acts as the full size
    set_graph(127, 3);
    run_tree();
    // empty, single vertex and start out of range give nothing
    set_graph(0, 0);
    run_tree();
    set_graph(1, 0);
    run_tree();
    set_graph(4, 63);
    run_tree();
    set_graph(2, 1);
    load_edge(1, 0, 16'hfffe, 1'b1);
    run_tree();
  endtask

  // random graphs: mostly well-formed loads followed by one or two runs
  task automatic test_random_graphs(input int budget);
    int sent;
    int n;
    int w;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, Nodes);
      set_graph(n, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, (n > 1 ? n : 2) - 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 1) == 0) ? 3 : 16'hffff;
      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 9) == 0)
          load_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1'($urandom));
        else
          load_edge($urandom_range(0, Nodes - 1), $urandom_range(0, Nodes - 1),
                    $urandom_range(0, w), $urandom_range(0, 9) < 7);
        sent++;
      end
      repeat ($urandom_range(1, 2)) begin
        run_tree();
        sent++;
      end
      no_gaps = 1'b0;
    end
  endtask

  // results cannot be held off, so every strobe is checked on its edge
  always @(posedge clk) begin
    tree_entry_t e;
    if (!rst && result_valid) begin
      result_count++;
      if (spanning_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result for vertex %0d", vertex_id));
      end else begin
        e = spanning_q.pop_front();
        if (vertex_id !== e.vid)
          report_mismatch($sformatf("vertex_id %0d, want %0d", vertex_id, e.vid));
        if (parent_vertex !== e.parent)
          report_mismatch($sformatf("vertex %0d parent %0d, want %0d",
                                    e.vid, parent_vertex, e.parent));
        if (tree_weight !== e.weight)
          report_mismatch($sformatf("vertex %0d weight %0d, want %0d",
                                    e.vid, tree_weight, e.weight));
        if (reachable !== e.reach)
          report_mismatch($sformatf("vertex %0d reachable %b, want %b",
                                    e.vid, reachable, e.reach));
        if (last !== e.lst)
          report_mismatch($sformatf("vertex %0d last %b, want %b", e.vid, last, e.lst));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Nodes * Nodes; i++) begin
      edge_weights[i] = '0;
      edge_exists[i]  = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_clear_matrix();
    test_special_cases();
    test_random_graphs(420);

    drain();
    repeat (50) @(posedge clk);
    if (spanning_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", spanning_q.size()));
    $display("covered %0d loads and %0d tree runs, %0d results checked",
             load_count, run_count, result_count);
    $display("graph sizes 0 to 127, roots in and out of range, ties and weight extremes");
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pmst_pkg.sv
hdl/pmst_ram.sv
hdl/pmst_ctrl.sv
hdl/pmst_dp.sv
hdl/prim_minimum_spanning_tree_core.sv
bench/testbench.sv
